// ===== design/opl_pkg.sv =====
package opl_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int DELTA_W     = COUNT_WIDTH + 1;
    localparam int CHANGE_W    = COUNT_WIDTH + 2;
    localparam int GAIN_W      = 24;
    localparam int OFFSET_W    = 32;
    localparam int LIMIT_W     = 15;
    localparam int DRIVE_W     = 48;

    // Signed products of an unsigned Q.8 gain (one extra sign bit) and a term
    localparam int PROD_P_W = GAIN_W + 1 + DELTA_W;
    localparam int PROD_I_W = GAIN_W + 1 + COUNT_WIDTH;
    localparam int PROD_D_W = GAIN_W + 1 + CHANGE_W;
    localparam int SUM_W    = ((PROD_D_W > OFFSET_W) ? PROD_D_W : OFFSET_W) + 2;
    localparam int CMP_W    = (SUM_W > DRIVE_W) ? SUM_W : DRIVE_W;
    localparam int CLAMP_W  = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0]   RST_GAIN_P = GAIN_W'(128000);
    localparam logic [GAIN_W-1:0]   RST_GAIN_I = GAIN_W'(768);
    localparam logic [GAIN_W-1:0]   RST_GAIN_D = GAIN_W'(10240);
    localparam logic [OFFSET_W-1:0] RST_OFFSET = '0;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT  = LIMIT_W'(15);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_OFFSET    = 3'd3,
        CFG_POS_LIMIT = 3'd4
    } t_cfg_idx;

    // Terms of one control tick, taken from the odometer state
    typedef struct packed {
        logic signed [COUNT_WIDTH-1:0] position;
        logic signed [DELTA_W-1:0]     delta;
        logic signed [CHANGE_W-1:0]    change;
    } t_terms;

    // Saturate the exact sum to the signed drive range
    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [SUM_W-1:0] sum
    );
        logic signed [CMP_W-1:0] s;
        logic signed [CMP_W-1:0] mx;
        logic signed [CMP_W-1:0] mn;
        s  = CMP_W'(sum);
        mx = {{(CMP_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
        mn = ~mx;
        if (s > mx) begin
            s = mx;
        end else if (s < mn) begin
            s = mn;
        end
        return s[DRIVE_W-1:0];
    endfunction

endpackage

// ===== design/odometer_pid_position_loop.sv =====
// Channel      | Valid        | Stall     | Payload
// -------------+--------------+-----------+-------------------------------------------
// item in      | i_valid      | o_stall   | i_action, i_sensor_level, i_moving_backward
// drive out    | o_valid      | i_stall   | o_drive_value
// config write | i_cfg_valid  | (ready: o_cfg_ready) | i_cfg_index, i_cfg_data
//
// One request is taken every cycle while o_stall is low; a control tick gives its
// drive value through the input register, product register and result register.
// The odometer state updates as a request leaves the input register, so
// back-to-back requests see each other's effect in order.
// Reset (synchronous, active low) empties the pipeline, clears the odometer and
// loads the default gains, offset and limit.
// A stall on the output holds the result register and backs up stage by stage;
// o_stall rises only once every stage holds a request.
module odometer_pid_position_loop
    import opl_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // item in
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  logic                      i_sensor_level,
    input  logic                      i_moving_backward,
    // drive out
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DRIVE_W-1:0] o_drive_value,
    // configuration write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration registers
    logic [GAIN_W-1:0]   r_gain_p;
    logic [GAIN_W-1:0]   r_gain_i;
    logic [GAIN_W-1:0]   r_gain_d;
    logic [OFFSET_W-1:0] r_offset;
    logic [LIMIT_W-1:0]  r_limit;

    // Stage A: input register
    logic r_a_valid;
    logic r_a_action;
    logic r_a_level;
    logic r_a_back;

    // Stage B: product register (control ticks only)
    logic                       r_b_valid;
    logic signed [PROD_P_W-1:0] r_b_prod_p;
    logic signed [PROD_I_W-1:0] r_b_prod_i;
    logic signed [PROD_D_W-1:0] r_b_prod_d;

    // Stage C: result register
    logic                      r_c_valid;
    logic signed [DRIVE_W-1:0] r_c_drive;

    logic                       a_move;
    logic                       b_move;
    logic                       c_move;
    logic                       accept;
    t_terms                     terms;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;
    logic signed [SUM_W-1:0]    sum;

    // A stage advances when the one after it is empty or advancing itself
    assign c_move  = !r_c_valid || !i_stall;
    assign b_move  = !r_b_valid || c_move;
    assign a_move  = !r_a_valid || b_move;
    assign accept  = i_valid && a_move;
    assign o_stall = !a_move;

    assign o_valid       = r_c_valid;
    assign o_drive_value = r_c_drive;

    // Writes must arrive only while idle; the block does not enforce this and takes them at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= RST_GAIN_P;
            r_gain_i <= RST_GAIN_I;
            r_gain_d <= RST_GAIN_D;
            r_offset <= RST_OFFSET;
            r_limit  <= RST_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GAIN_P:    r_gain_p <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    r_gain_i <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    r_gain_d <= i_cfg_data[GAIN_W-1:0];
                CFG_OFFSET:    r_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_POS_LIMIT: r_limit  <= i_cfg_data[LIMIT_W-1:0];
                default:       ; // drop writes beyond the register list
            endcase
        end
    end

    // Stage A: capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_move) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_action <= i_action;
            r_a_level  <= i_sensor_level;
            r_a_back   <= i_moving_backward;
        end
    end

    // Odometer state: step on sample ticks, form terms and clamp on control ticks
    opl_odometer u_odometer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (r_a_valid && b_move),
        .i_action   (r_a_action),
        .i_level    (r_a_level),
        .i_backward (r_a_back),
        .i_limit    (r_limit),
        .o_terms    (terms)
    );

    // Three independent multiplies of the Q.8 gains by the terms
    assign prod_p = PROD_P_W'($signed({1'b0, r_gain_p})) * PROD_P_W'(terms.delta);
    assign prod_i = PROD_I_W'($signed({1'b0, r_gain_i})) * PROD_I_W'(terms.position);
    assign prod_d = PROD_D_W'($signed({1'b0, r_gain_d})) * PROD_D_W'(terms.change);

    // Stage B: sample ticks leave no result and drop out here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_move) begin
            r_b_valid <= r_a_valid && r_a_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_b_prod_p <= prod_p;
            r_b_prod_i <= prod_i;
            r_b_prod_d <= prod_d;
        end
    end

    // Exact sum, then saturate to the drive range
    assign sum = SUM_W'(r_b_prod_p) + SUM_W'(r_b_prod_i) + SUM_W'(r_b_prod_d)
               + SUM_W'($signed(r_offset));

    // Stage C: hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_move) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_move) begin
            r_c_drive <= sat_drive(sum);
        end
    end

endmodule

// ===== design/opl_odometer.sv =====
module opl_odometer
    import opl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_action,
    input  logic               i_level,
    input  logic               i_backward,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_terms             o_terms
);

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = ~CNT_MAX;

    logic                          r_level;
    logic signed [COUNT_WIDTH-1:0] r_pos;
    logic signed [COUNT_WIDTH-1:0] r_pos_last;
    logic signed [DELTA_W-1:0]     r_prev_delta;

    logic                          n_level;
    logic signed [COUNT_WIDTH-1:0] n_pos;
    logic signed [COUNT_WIDTH-1:0] n_pos_last;
    logic signed [DELTA_W-1:0]     n_prev_delta;

    logic signed [DELTA_W-1:0]     delta;
    logic signed [CHANGE_W-1:0]    change;
    logic signed [CLAMP_W-1:0]     lim_w;
    logic signed [CLAMP_W-1:0]     pos_w;
    logic signed [COUNT_WIDTH-1:0] pos_clamped;

    assign delta  = DELTA_W'(r_pos) - DELTA_W'(r_pos_last);
    assign change = CHANGE_W'(delta) - CHANGE_W'(r_prev_delta);

    assign o_terms.position = r_pos;
    assign o_terms.delta    = delta;
    assign o_terms.change   = change;

    // Anti-windup clamp, compared wide enough for any limit
    always_comb begin
        lim_w = $signed(CLAMP_W'(i_limit));
        pos_w = CLAMP_W'(r_pos);
        if (pos_w > lim_w) begin
            pos_clamped = COUNT_WIDTH'(lim_w);
        end else if (pos_w < -lim_w) begin
            pos_clamped = COUNT_WIDTH'(-lim_w);
        end else begin
            pos_clamped = r_pos;
        end
    end

    always_comb begin
        n_level      = r_level;
        n_pos        = r_pos;
        n_pos_last   = r_pos_last;
        n_prev_delta = r_prev_delta;
        if (i_step) begin
            if (!i_action) begin
                n_level = i_level;
                if (i_level != r_level) begin
                    if (i_backward) begin
                        if (r_pos != CNT_MIN) begin
                            n_pos = r_pos - COUNT_WIDTH'(1);
                        end
                    end else begin
                        if (r_pos != CNT_MAX) begin
                            n_pos = r_pos + COUNT_WIDTH'(1);
                        end
                    end
                end
            end else begin
                n_pos        = pos_clamped;
                n_pos_last   = pos_clamped;
                n_prev_delta = delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level      <= 1'b0;
            r_pos        <= '0;
            r_pos_last   <= '0;
            r_prev_delta <= '0;
        end else begin
            r_level      <= n_level;
            r_pos        <= n_pos;
            r_pos_last   <= n_pos_last;
            r_prev_delta <= n_prev_delta;
        end
    end

endmodule
